// ===== sv/cbm_pkg.sv =====
// Shared constants and codes for the cartridge bank mapper.
// No dependencies; every other file imports this package.
package cbm_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int TARGET_W   = 2;
  localparam int OFFSET_W   = 22;
  localparam int COUNT_W    = 9;
  localparam int PAGE_W     = 8;
  localparam int STEP_W     = $clog2(PAGE_W);
  localparam int IN_SLOT_W  = 14;
  localparam int REGION_W   = 3;

  localparam int RAM_BYTES   = 8192;
  localparam int SRAM_BYTES  = 32768;
  localparam int RAM_OFF_W   = $clog2(RAM_BYTES);
  localparam int SRAM_OFF_W  = $clog2(SRAM_BYTES);

  localparam int FC_DEPTH = 4;
  localparam int FC_IDX_W = $clog2(FC_DEPTH);

  localparam logic [ADDR_W-1:0] MAPPER_BASE = 16'hFFFC;

  localparam logic [REGION_W-1:0] REGION_SLOT1_FIRST = 3'd2;
  localparam logic [REGION_W-1:0] REGION_SLOT2_FIRST = 3'd4;
  localparam logic [REGION_W-1:0] REGION_RAM_FIRST   = 3'd6;

  localparam logic [TARGET_W-1:0] TGT_ROM  = 2'd0;
  localparam logic [TARGET_W-1:0] TGT_SRAM = 2'd1;
  localparam logic [TARGET_W-1:0] TGT_RAM  = 2'd2;
  localparam logic [TARGET_W-1:0] TGT_DROP = 2'd3;

  localparam logic [FC_IDX_W-1:0] FC_SRAM_CTRL = 2'd0;
  localparam logic [FC_IDX_W-1:0] FC_SLOT0     = 2'd1;
  localparam logic [FC_IDX_W-1:0] FC_SLOT1     = 2'd2;
  localparam logic [FC_IDX_W-1:0] FC_SLOT2     = 2'd3;

  localparam int SRAM_ENABLE_BIT = 3;
  localparam int SRAM_BANK_BIT   = 2;

  localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = 9'd1;
  localparam logic [PAGE_W-1:0]  SLOT0_RESET      = 8'd0;
  localparam logic [PAGE_W-1:0]  SLOT1_RESET      = 8'd1;
  localparam logic [PAGE_W-1:0]  SLOT2_RESET      = 8'd0;

endpackage

// ===== sv/cbm_req_if.sv =====
// Request channel of the bank mapper: one CPU bus access per word.
// Depends on cbm_pkg for field widths.
interface cbm_req_if import cbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [ADDR_W-1:0]   cpu_address;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, req_type, cpu_address, write_data, input ready);
  modport sink   (input valid, req_type, cpu_address, write_data, output ready);
endinterface

// ===== sv/cbm_rsp_if.sv =====
// Response channel of the bank mapper: one translated access per word.
// Depends on cbm_pkg for field widths.
interface cbm_rsp_if import cbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TARGET_W-1:0]   target;
  logic [OFFSET_W-1:0]   physical_offset;
  logic                  sram_used;

  modport source (output valid, target, physical_offset, sram_used, input ready);
  modport sink   (input valid, target, physical_offset, sram_used, output ready);
endinterface

// ===== sv/cartridge_bank_mapper_top.sv =====
// Cartridge bank mapper: translates one CPU bus access per request word into a
// target store and byte offset. Reads and writes that do not hit the mapper
// registers are loaded into the output register at the edge that takes them
// when the output is free, else they wait in ST_DONE until it is. A write at
// 0xFFFC-0xFFFF first passes the restoring remainder unit that reduces page
// numbers modulo rom_page_count; then the mapper update is applied and the
// result is loaded into the output register. The request side is not ready
// meanwhile. A finished result waits in an output register while the next
// request is taken.
// Depends on cbm_pkg, cbm_req_if, cbm_rsp_if and cbm_mod_unit.
module cartridge_bank_mapper_top import cbm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  cbm_req_if.sink            req,
  cbm_rsp_if.source          rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_DONE} state_t;

  state_t               state;
  logic [COUNT_W-1:0]   rom_page_count;
  logic [DATA_W-1:0]    frame_control [FC_DEPTH];
  logic [PAGE_W-1:0]    slot0_page;
  logic [PAGE_W-1:0]    slot1_page;
  logic [PAGE_W-1:0]    slot2_page;
  logic                 slot2_sram_on;
  logic                 slot2_sram_bank;
  logic                 sram_used_flag;

  logic                 out_valid;
  logic                 out_valid_next;
  logic [TARGET_W-1:0]  out_target;
  logic [OFFSET_W-1:0]  out_offset;
  logic                 out_sram_used;

  logic [TARGET_W-1:0]  pend_target;
  logic [OFFSET_W-1:0]  pend_offset;
  logic [FC_IDX_W-1:0]  pend_reg;
  logic [DATA_W-1:0]    pend_data;

  logic [REGION_W-1:0]  region;
  logic [PAGE_W-1:0]    rom_page;
  logic [TARGET_W-1:0]  acc_target;
  logic [OFFSET_W-1:0]  acc_offset;
  logic                 accept;
  logic                 is_mapper;
  logic                 out_free;
  logic                 load_direct;
  logic                 load_done;
  logic                 div_done;
  logic [PAGE_W-1:0]    div_rem;
  logic [PAGE_W-1:0]    div_operand;

  assign req.ready   = (state == ST_IDLE);
  assign accept      = req.valid && req.ready;
  assign is_mapper   = req.req_type && (req.cpu_address >= MAPPER_BASE);
  assign out_free    = !out_valid || rsp.ready;
  assign load_direct = (state == ST_IDLE) && accept && !is_mapper && out_free;
  assign load_done   = (state == ST_DONE) && out_free;
  assign out_valid_next = load_direct || load_done || (out_valid && !rsp.ready);

  assign rsp.valid           = out_valid;
  assign rsp.target          = out_target;
  assign rsp.physical_offset = out_offset;
  assign rsp.sram_used       = out_sram_used;

  assign region = req.cpu_address[ADDR_W-1 -: REGION_W];

  always_comb begin
    if (region < REGION_SLOT1_FIRST) begin
      rom_page = slot0_page;
    end else if (region < REGION_SLOT2_FIRST) begin
      rom_page = slot1_page;
    end else begin
      rom_page = slot2_page;
    end
    if (region >= REGION_RAM_FIRST) begin
      acc_target = TGT_RAM;
      acc_offset = OFFSET_W'(req.cpu_address[RAM_OFF_W-1:0]);
    end else if (region >= REGION_SLOT2_FIRST && slot2_sram_on) begin
      acc_target = TGT_SRAM;
      acc_offset = OFFSET_W'(SRAM_OFF_W'({slot2_sram_bank,
                                           req.cpu_address[IN_SLOT_W-1:0]}));
    end else if (req.req_type) begin
      acc_target = TGT_DROP;
      acc_offset = '0;
    end else begin
      acc_target = TGT_ROM;
      acc_offset = {rom_page, req.cpu_address[IN_SLOT_W-1:0]};
    end
  end

  assign div_operand = (req.cpu_address[FC_IDX_W-1:0] == FC_SRAM_CTRL) ?
                       frame_control[FC_SLOT2] : req.write_data;

  cbm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && is_mapper),
    .dividend  (div_operand),
    .modulus   (rom_page_count),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                   <= ST_IDLE;
      out_valid               <= 1'b0;
      rom_page_count          <= PAGE_COUNT_RESET;
      frame_control[FC_SRAM_CTRL] <= '0;
      frame_control[FC_SLOT0] <= '0;
      frame_control[FC_SLOT1] <= DATA_W'(1);
      frame_control[FC_SLOT2] <= '0;
      slot0_page              <= SLOT0_RESET;
      slot1_page              <= SLOT1_RESET;
      slot2_page              <= SLOT2_RESET;
      slot2_sram_on           <= 1'b0;
      slot2_sram_bank         <= 1'b0;
      sram_used_flag          <= 1'b0;
    end else begin
      if (cfg_we) begin
        rom_page_count <= cfg_wdata;
      end
      out_valid <= out_valid_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_mapper) begin
              state <= ST_DIVIDE;
            end else if (!out_free) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            frame_control[pend_reg] <= pend_data;
            case (pend_reg)
              FC_SRAM_CTRL: begin
                if (pend_data[SRAM_ENABLE_BIT]) begin
                  slot2_sram_on   <= 1'b1;
                  slot2_sram_bank <= pend_data[SRAM_BANK_BIT];
                  sram_used_flag  <= 1'b1;
                end else begin
                  slot2_sram_on <= 1'b0;
                  slot2_page    <= div_rem;
                end
              end
              FC_SLOT0: slot0_page <= div_rem;
              FC_SLOT1: slot1_page <= div_rem;
              default: begin
                if (!frame_control[FC_SRAM_CTRL][SRAM_ENABLE_BIT]) begin
                  slot2_page <= div_rem;
                end
              end
            endcase
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_target <= acc_target;
      pend_offset <= acc_offset;
      pend_reg    <= req.cpu_address[FC_IDX_W-1:0];
      pend_data   <= req.write_data;
    end
    if (load_direct) begin
      out_target    <= acc_target;
      out_offset    <= acc_offset;
      out_sram_used <= sram_used_flag;
    end else if (load_done) begin
      out_target    <= pend_target;
      out_offset    <= pend_offset;
      out_sram_used <= sram_used_flag;
    end
  end

endmodule

// ===== sv/cbm_mod_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle, page byte mod page count.
// Depends on cbm_pkg; used by cartridge_bank_mapper_top.
module cbm_mod_unit import cbm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PAGE_W-1:0]  dividend,
  input  logic [COUNT_W-1:0] modulus,
  output logic               done,
  output logic [PAGE_W-1:0]  remainder
);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [PAGE_W-1:0]  shift_reg;
  logic [PAGE_W-1:0]  rem;
  logic [COUNT_W-1:0] divisor;
  logic [COUNT_W-1:0] trial;
  logic [COUNT_W-1:0] diff;
  logic [PAGE_W-1:0]  rem_next;

  assign trial    = {1'b0, rem[PAGE_W-2:0], shift_reg[PAGE_W-1]};
  assign diff     = trial - divisor;
  assign rem_next = (trial >= divisor) ? diff[PAGE_W-1:0] : trial[PAGE_W-1:0];
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start || (busy && step != '0);
      done <= !start && busy && step == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step      <= STEP_W'(PAGE_W - 1);
      rem       <= '0;
      shift_reg <= dividend;
      divisor   <= (modulus == '0) ? COUNT_W'(1) : modulus;
    end else if (busy) begin
      step      <= step - STEP_W'(1);
      rem       <= rem_next;
      shift_reg <= {shift_reg[PAGE_W-2:0], 1'b0};
    end
  end

endmodule

// ===== tb/cartridge_bank_mapper_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cartridge_bank_mapper_top: directed and random CPU accesses
// with random stalls on both channels. A built-in slot model predicts each result.
// Depends on cbm_pkg, cbm_req_if, cbm_rsp_if and the mapper RTL.
module cartridge_bank_mapper_top_test;
  import cbm_pkg::*;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam int RESET_CYCLES      = 12;
  localparam int SETTLE_CYCLES     = 12;
  localparam int IDLE_LIMIT        = 2000;
  localparam int ITEMS_PER_SETTING = 170;
  localparam int MAX_WAIT          = 8;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [OFFSET_W-1:0] physical_offset;
    logic                sram_used;
  } xlat_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  cbm_req_if req_bus ();
  cbm_rsp_if rsp_bus ();

  cartridge_bank_mapper_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  logic [COUNT_W-1:0] page_count;
  logic [DATA_W-1:0]  frame_ctl [FC_DEPTH];
  logic [PAGE_W-1:0]  slot0_pg;
  logic [PAGE_W-1:0]  slot1_pg;
  logic [PAGE_W-1:0]  slot2_pg;
  logic               sram_on;
  logic               sram_bank;
  logic               sram_seen;

  xlat_t pending_xlat [$];
  int    errors = 0;
  int    n_access = 0;
  int    n_mapper = 0;
  int    n_settings = 0;
  int    idle_cycles = 0;
  bit    steady = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void reset_slot_model();
    page_count = PAGE_COUNT_RESET;
    frame_ctl[FC_SRAM_CTRL] = '0;
    frame_ctl[FC_SLOT0] = '0;
    frame_ctl[FC_SLOT1] = 8'd1;
    frame_ctl[FC_SLOT2] = '0;
    slot0_pg = SLOT0_RESET;
    slot1_pg = SLOT1_RESET;
    slot2_pg = SLOT2_RESET;
    sram_on = 1'b0;
    sram_bank = 1'b0;
    sram_seen = 1'b0;
  endfunction

  function automatic logic [PAGE_W-1:0] reduce_page(logic [DATA_W-1:0] v);
    int n;
    n = (page_count == '0) ? 1 : int'(page_count);
    return PAGE_W'(int'(v) % n);
  endfunction

  function automatic xlat_t translate_access(logic wr, logic [ADDR_W-1:0] addr,
                                             logic [DATA_W-1:0] data);
    xlat_t               x;
    logic [REGION_W-1:0] region;
    logic [PAGE_W-1:0]   pg;
    logic [FC_IDX_W-1:0] reg_idx;
    region = addr[ADDR_W-1 -: REGION_W];
    x = '0;
    if (region >= REGION_RAM_FIRST) begin
      x.target = TGT_RAM;
      x.physical_offset = OFFSET_W'(addr[RAM_OFF_W-1:0]);
    end else if (region >= REGION_SLOT2_FIRST && sram_on) begin
      x.target = TGT_SRAM;
      x.physical_offset = OFFSET_W'({sram_bank, addr[IN_SLOT_W-1:0]});
    end else if (wr == REQ_WRITE) begin
      x.target = TGT_DROP;
    end else begin
      if (region < REGION_SLOT1_FIRST) pg = slot0_pg;
      else if (region < REGION_SLOT2_FIRST) pg = slot1_pg;
      else pg = slot2_pg;
      x.target = TGT_ROM;
      x.physical_offset = {pg, addr[IN_SLOT_W-1:0]};
    end
    if (wr == REQ_WRITE && addr >= MAPPER_BASE) begin
      reg_idx = addr[FC_IDX_W-1:0];
      frame_ctl[reg_idx] = data;
      case (reg_idx)
        FC_SRAM_CTRL: begin
          if (data[SRAM_ENABLE_BIT]) begin
            sram_on = 1'b1;
            sram_bank = data[SRAM_BANK_BIT];
            sram_seen = 1'b1;
          end else begin
            sram_on = 1'b0;
            slot2_pg = reduce_page(frame_ctl[FC_SLOT2]);
          end
        end
        FC_SLOT0: slot0_pg = reduce_page(data);
        FC_SLOT1: slot1_pg = reduce_page(data);
        default: begin
          if (!frame_ctl[FC_SRAM_CTRL][SRAM_ENABLE_BIT]) slot2_pg = reduce_page(data);
        end
      endcase
    end
    x.sram_used = sram_seen;
    return x;
  endfunction

  task automatic send_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= wr;
    req_bus.cpu_address <= addr;
    req_bus.write_data  <= data;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    pending_xlat.push_back(translate_access(wr, addr, data));
    n_access++;
    if (wr == REQ_WRITE && addr >= MAPPER_BASE) n_mapper++;
  endtask

  task automatic send_random_access();
    int                kind;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      wr = REQ_WRITE;
      addr = MAPPER_BASE + ADDR_W'($urandom_range(0, FC_DEPTH - 1));
    end else if (kind == 3) begin
      wr = REQ_READ;
      addr = ADDR_W'($urandom_range(16'h8000, 16'hBFFF));
    end else begin
      wr = logic'($urandom_range(0, 1));
      addr = ADDR_W'($urandom_range(0, 16'hFFFF));
    end
    send_access(wr, addr, DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_page_count(input logic [COUNT_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    page_count = value;
    n_settings++;
  endtask

  task automatic test_reset_mapping();
    send_access(REQ_READ, 16'h0000, 8'h00);
    send_access(REQ_READ, 16'h3FFF, 8'hFF);
    send_access(REQ_READ, 16'h4000, 8'h00);
    send_access(REQ_READ, 16'h7FFF, 8'h00);
    send_access(REQ_READ, 16'h8000, 8'h00);
    send_access(REQ_READ, 16'hBFFF, 8'h00);
    send_access(REQ_READ, 16'hC000, 8'h00);
    send_access(REQ_READ, 16'hFFFF, 8'h00);
    send_access(REQ_WRITE, 16'h1234, 8'hA5);
    send_access(REQ_WRITE, 16'hC123, 8'h5A);
  endtask

  task automatic test_mapper_registers();
    set_page_count(9'd256);
    send_access(REQ_WRITE, 16'hFFFD, 8'hFF);
    send_access(REQ_READ, 16'h0000, 8'h00);
    send_access(REQ_WRITE, 16'hFFFE, 8'h80);
    send_access(REQ_READ, 16'h7FFF, 8'h00);
    send_access(REQ_WRITE, 16'hFFFF, 8'h7F);
    send_access(REQ_READ, 16'h8000, 8'h00);
    send_access(REQ_WRITE, 16'hFFFC, 8'h08);
    send_access(REQ_READ, 16'hA000, 8'h00);
    send_access(REQ_WRITE, 16'hBFFF, 8'h5A);
    send_access(REQ_WRITE, 16'hFFFF, 8'h03);
    send_access(REQ_WRITE, 16'hFFFC, 8'h0C);
    send_access(REQ_READ, 16'h8001, 8'h00);
    send_access(REQ_WRITE, 16'h4000, 8'h11);
    send_access(REQ_WRITE, 16'hFFFC, 8'h00);
    send_access(REQ_READ, 16'hBFFF, 8'h00);
  endtask

  task automatic test_page_count_sweep();
    logic [COUNT_W-1:0] counts [9] = '{9'd5, 9'd0, 9'd1, 9'd511, 9'd3, 9'd37,
                                       9'd255, 9'd170, 9'd85};
    foreach (counts[i]) begin
      set_page_count(counts[i]);
      steady = (i % 3 == 2);
      repeat (ITEMS_PER_SETTING) send_random_access();
      steady = 1'b0;
    end
  endtask

  initial begin : result_sink
    int stall;
    rsp_bus.ready <= 1'b0;
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
    end
  end

  always @(posedge clk) begin : result_check
    xlat_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_xlat.size() == 0) begin
        errors++;
        $error("result word with no pending access");
      end else begin
        want = pending_xlat.pop_front();
        if (rsp_bus.target !== want.target) begin
          errors++;
          $error("target: expected %0d, actual %0d", want.target, rsp_bus.target);
        end
        if (rsp_bus.physical_offset !== want.physical_offset) begin
          errors++;
          $error("physical_offset: expected 0x%0h, actual 0x%0h",
                 want.physical_offset, rsp_bus.physical_offset);
        end
        if (rsp_bus.sram_used !== want.sram_used) begin
          errors++;
          $error("sram_used: expected %0d, actual %0d", want.sram_used, rsp_bus.sram_used);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("cartridge_bank_mapper_top_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_slot_model();
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.req_type    <= REQ_READ;
    req_bus.cpu_address <= '0;
    req_bus.write_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_mapping();
    test_mapper_registers();
    test_page_count_sweep();
    settle();
    $display("Covered %0d bus accesses, %0d of them mapper register writes,", n_access, n_mapper);
    $display("across %0d page count settings with random stalls on both channels.", n_settings);
    if (errors == 0 && pending_xlat.size() == 0) begin
      $display("cartridge_bank_mapper_top_test OK");
    end else begin
      $display("cartridge_bank_mapper_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cbm_pkg.sv
sv/cbm_req_if.sv
sv/cbm_rsp_if.sv
sv/cbm_mod_unit.sv
sv/cartridge_bank_mapper_top.sv
tb/cartridge_bank_mapper_top_test.sv
